### rtl/isl_pkg.sv
package isl_pkg;

   typedef enum logic [2:0] {
      MODE_READ   = 3'd0,
      MODE_INSERT = 3'd1,
      MODE_REMOVE = 3'd2,
      MODE_PUSH   = 3'd3,
      MODE_POP    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_READ,
      OP_INSERT,
      OP_REMOVE,
      OP_ERROR
   } op_kind_type;

   typedef enum logic [1:0] {
      RD_POS,
      RD_ABOVE,
      RD_BELOW
   } rd_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_LATCH,
      S_DN_CHECK,
      S_DN_WRITE,
      S_UP_CHECK,
      S_UP_WRITE,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mem_rd;
      rd_sel_type rd_sel;
      logic       mem_wr;
      logic       wr_value;
      logic       ptr_inc;
      logic       ptr_dec;
      logic       data_latch;
      logic       count_inc;
      logic       count_dec;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      op_kind_type req_kind;
      logic        up_more;
      logic        dn_more;
   } stat_type;

endpackage

### rtl/isl_ram.sv
module isl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/isl_datapath.sv
module isl_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          req_mode,
   input  logic [7:0]          req_index,
   input  logic signed [31:0]  req_value,
   input  isl_pkg::cmd_type    cmd,
   output isl_pkg::stat_type   stat,
   output logic signed [31:0]  rsp_data_out,
   output logic [1:0]          rsp_status,
   output logic [8:0]          rsp_count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;
   localparam int OW   = (CW > 9) ? CW : 9;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [CW-1:0]          fill_ff, fill_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [31:0]            value_ff;
   logic [31:0]            data_ff, data_in;
   isl_pkg::status_type    code_ff, code_in;
   logic [31:0]            rsp_data_ff;
   isl_pkg::status_type    rsp_status_ff;
   logic [8:0]             rsp_count_ff;

   logic [CMPW-1:0]        idx_ext, fill_ext;
   logic [CW-1:0]          fill_m1;
   logic [CW-1:0]          ptr_up;
   logic [OW-1:0]          fill_wide;
   logic                   full, empty;
   isl_pkg::op_kind_type   kind;
   logic [AW-1:0]          start_ptr;

   logic                   mem_rd_en, mem_wr_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [31:0]            mem_wr_data, mem_rd_data;

   // Request decode and range checks, done while the request is offered.
   always_comb begin
      idx_ext  = CMPW'(req_index);
      fill_ext = CMPW'(fill_ff);
      fill_m1  = fill_ff - CW'(1);
      full     = (fill_ff == DEPTH_C);
      empty    = (fill_ff == '0);
      kind     = isl_pkg::OP_ERROR;
      code_in  = isl_pkg::ST_RANGE;
      pos_in   = idx_ext[AW-1:0];
      case (isl_pkg::mode_type'(req_mode))
         isl_pkg::MODE_READ: begin
            if (idx_ext < fill_ext) begin
               kind    = isl_pkg::OP_READ;
               code_in = isl_pkg::ST_OK;
            end
         end
         isl_pkg::MODE_INSERT: begin
            // The index check takes priority over the full check.
            if (idx_ext > fill_ext) begin
               code_in = isl_pkg::ST_RANGE;
            end else if (full) begin
               code_in = isl_pkg::ST_FULL;
            end else begin
               kind    = isl_pkg::OP_INSERT;
               code_in = isl_pkg::ST_OK;
            end
         end
         isl_pkg::MODE_REMOVE: begin
            if (idx_ext < fill_ext) begin
               kind    = isl_pkg::OP_REMOVE;
               code_in = isl_pkg::ST_OK;
            end
         end
         isl_pkg::MODE_PUSH: begin
            pos_in = fill_ff[AW-1:0];
            if (full) begin
               code_in = isl_pkg::ST_FULL;
            end else begin
               kind    = isl_pkg::OP_INSERT;
               code_in = isl_pkg::ST_OK;
            end
         end
         isl_pkg::MODE_POP: begin
            pos_in = fill_m1[AW-1:0];
            if (!empty) begin
               kind    = isl_pkg::OP_REMOVE;
               code_in = isl_pkg::ST_OK;
            end
         end
         default: begin
            kind    = isl_pkg::OP_ERROR;
            code_in = isl_pkg::ST_RANGE;
         end
      endcase
      // An insert shifts from the top of the list down to its position.
      start_ptr = (kind == isl_pkg::OP_INSERT) ? fill_ff[AW-1:0] : pos_in;
   end

   always_comb begin
      ptr_up        = CW'(ptr_ff) + CW'(1);
      stat.req_kind = kind;
      stat.up_more  = (ptr_ff > pos_ff);
      stat.dn_more  = (ptr_up < fill_ff);
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.count_inc) begin
         fill_in = fill_ff + CW'(1);
      end else if (cmd.count_dec) begin
         fill_in = fill_ff - CW'(1);
      end
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = start_ptr;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + AW'(1);
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - AW'(1);
      end
      data_in = data_ff;
      if (cmd.load) begin
         data_in = '0;
      end else if (cmd.data_latch) begin
         data_in = mem_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      data_ff <= data_in;
      if (cmd.load) begin
         pos_ff   <= pos_in;
         value_ff <= req_value;
         code_ff  <= code_in;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff   <= data_ff;
         rsp_status_ff <= code_ff;
         rsp_count_ff  <= fill_wide[8:0];
      end
   end

   always_comb begin
      fill_wide = OW'(fill_ff);
      case (cmd.rd_sel)
         isl_pkg::RD_POS:   mem_rd_addr = pos_ff;
         isl_pkg::RD_ABOVE: mem_rd_addr = ptr_ff + AW'(1);
         isl_pkg::RD_BELOW: mem_rd_addr = ptr_ff - AW'(1);
         default:           mem_rd_addr = pos_ff;
      endcase
      mem_rd_en   = cmd.mem_rd;
      mem_wr_en   = cmd.mem_wr;
      mem_wr_data = cmd.wr_value ? value_ff : mem_rd_data;
   end

   isl_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

   a_no_inc_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> (fill_ff != DEPTH_C))
      else $error("count raised on a full list");

   a_no_dec_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.count_dec |-> (fill_ff != '0))
      else $error("count lowered on an empty list");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("count beyond the list depth");

endmodule

### rtl/isl_ctrl.sv
module isl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  isl_pkg::stat_type stat,
   output isl_pkg::cmd_type  cmd
);

   isl_pkg::state_type   state_ff, state_in;
   isl_pkg::op_kind_type kind_ff, kind_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         isl_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in = stat.req_kind;
               case (stat.req_kind)
                  isl_pkg::OP_READ:   state_in = isl_pkg::S_FETCH;
                  isl_pkg::OP_REMOVE: state_in = isl_pkg::S_FETCH;
                  isl_pkg::OP_INSERT: state_in = isl_pkg::S_UP_CHECK;
                  default:            state_in = isl_pkg::S_RESULT;
               endcase
            end
         end
         isl_pkg::S_FETCH: state_in = isl_pkg::S_LATCH;
         isl_pkg::S_LATCH: begin
            state_in = (kind_ff == isl_pkg::OP_REMOVE) ? isl_pkg::S_DN_CHECK
                                                       : isl_pkg::S_RESULT;
         end
         isl_pkg::S_DN_CHECK: begin
            state_in = stat.dn_more ? isl_pkg::S_DN_WRITE : isl_pkg::S_RESULT;
         end
         isl_pkg::S_DN_WRITE: state_in = isl_pkg::S_DN_CHECK;
         isl_pkg::S_UP_CHECK: begin
            state_in = stat.up_more ? isl_pkg::S_UP_WRITE : isl_pkg::S_RESULT;
         end
         isl_pkg::S_UP_WRITE: state_in = isl_pkg::S_UP_CHECK;
         isl_pkg::S_RESULT: begin
            if (out_free) begin
               state_in = isl_pkg::S_IDLE;
            end
         end
         default: state_in = isl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = isl_pkg::RD_POS;
      req_stall  = 1'b1;
      case (state_ff)
         isl_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         isl_pkg::S_FETCH: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = isl_pkg::RD_POS;
         end
         isl_pkg::S_LATCH: cmd.data_latch = 1'b1;
         isl_pkg::S_DN_CHECK: begin
            if (stat.dn_more) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = isl_pkg::RD_ABOVE;
            end else begin
               cmd.count_dec = 1'b1;
            end
         end
         isl_pkg::S_DN_WRITE: begin
            cmd.mem_wr  = 1'b1;
            cmd.ptr_inc = 1'b1;
         end
         isl_pkg::S_UP_CHECK: begin
            if (stat.up_more) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = isl_pkg::RD_BELOW;
            end else begin
               // The gap has reached the insert position: drop the new value in.
               cmd.mem_wr    = 1'b1;
               cmd.wr_value  = 1'b1;
               cmd.count_inc = 1'b1;
            end
         end
         isl_pkg::S_UP_WRITE: begin
            cmd.mem_wr  = 1'b1;
            cmd.ptr_dec = 1'b1;
         end
         isl_pkg::S_RESULT: cmd.rsp_load = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isl_pkg::S_IDLE;
         kind_ff      <= isl_pkg::OP_ERROR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_shows_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("result register loaded but no beat offered");

   a_dn_write_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == isl_pkg::S_DN_WRITE) |-> ($past(state_ff) == isl_pkg::S_DN_CHECK))
      else $error("downward shift write without a preceding read");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == isl_pkg::S_RESULT) && rsp_valid_ff && rsp_stall
      |=> (state_ff == isl_pkg::S_RESULT))
      else $error("result overwritten while the previous beat is stalled");

endmodule

### rtl/indexed_list_store_top.sv
// Ordered list of up to DEPTH signed 32-bit entries held in one RAM with a
// registered read and separate read and write ports, plus a live count. One
// request is worked at a time; the next request is taken once the current result
// has been placed in the output register, even if that beat is still stalled. An
// insert or remove at position p in a list of n entries moves each entry between p
// and the top of the list one at a time, a RAM read followed by a write (push and
// pop are the cases p = n and p = n - 1). No clearing pass is needed after reset.
module indexed_list_store_top #(
   parameter int DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [7:0]         req_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_data_out,
   output logic [1:0]         rsp_status,
   output logic [8:0]         rsp_count
);

   isl_pkg::cmd_type  cmd;
   isl_pkg::stat_type stat;

   isl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   isl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_mode     (req_mode),
      .req_index    (req_index),
      .req_value    (req_value),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

endmodule
